// ===== rtl/uae_pkg.sv =====
// Types, codes and pattern tables shared by the User-Agent extractor.
package uae_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 13;
	localparam int MIN_LEN_BITS   = 8;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_PAYLOAD_LEN = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_AGENT_LEN   = 2'd1;

	localparam logic [MIN_LEN_BITS-1:0] MIN_PAYLOAD_RST = 8'd16;
	localparam int                      MAX_AGENT_RST   = 256;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [3:0] HTTP_LEN = 4'd4;
	localparam logic [3:0] UA_LEN   = 4'd12;

	// method match progress: G, GE / P, PO, POS
	localparam logic [3:0] M_IDLE = 4'd0;
	localparam logic [3:0] M_G    = 4'd1;
	localparam logic [3:0] M_GE   = 4'd2;
	localparam logic [3:0] M_P    = 4'd5;
	localparam logic [3:0] M_PO   = 4'd6;
	localparam logic [3:0] M_POS  = 4'd7;

	typedef enum logic [2:0] {
		PH_METHOD  = 3'd0,
		PH_FIRST   = 3'd1,
		PH_HEADERS = 3'd2,
		PH_AGENT   = 3'd3,
		PH_DONE    = 3'd4,
		PH_FAILED  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT       = 3'd1,
		ST_METHOD      = 3'd2,
		ST_NO_LINE_END = 3'd3,
		ST_NO_HTTP     = 3'd4,
		ST_UNTERM      = 3'd5,
		ST_NO_AGENT    = 3'd6,
		ST_NON_ASCII   = 3'd7
	} status_t;

	function automatic logic [7:0] http_char(input logic [1:0] k);
		logic [7:0] c;
		unique case (k)
			2'd0: c = "H";
			2'd1: c = "T";
			2'd2: c = "T";
			2'd3: c = "P";
		endcase
		return c;
	endfunction

	function automatic logic [7:0] ua_char(input logic [3:0] k);
		logic [7:0] c;
		unique case (k)
			4'd0:    c = "U";
			4'd1:    c = "s";
			4'd2:    c = "e";
			4'd3:    c = "r";
			4'd4:    c = "-";
			4'd5:    c = "A";
			4'd6:    c = "g";
			4'd7:    c = "e";
			4'd8:    c = "n";
			4'd9:    c = "t";
			4'd10:   c = ":";
			4'd11:   c = " ";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/uae_if.sv =====
// Handshake channels of the User-Agent extractor: payload bytes, verdicts, register writes.
interface uae_pkt_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface uae_verdict_if #(
	parameter int POSITION_BITS = 16,
	parameter int LENGTH_BITS   = 12
);
	logic                     valid;
	logic                     ready;
	logic [2:0]               status;
	logic [POSITION_BITS-1:0] agent_start;
	logic [LENGTH_BITS-1:0]   agent_length;

	modport source (output valid, status, agent_start, agent_length, input ready);
	modport sink   (input valid, status, agent_start, agent_length, output ready);
endinterface

interface uae_cfg_if import uae_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/uae_cfg_regs.sv =====
// Configuration registers: minimum payload length and the clamped agent length cap.
module uae_cfg_regs import uae_pkg::*; #(
	parameter int LENGTH_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	uae_cfg_if.sink                 cfg,
	output logic [MIN_LEN_BITS-1:0] min_len_q,
	output logic [LENGTH_BITS-1:0]  cap_q
);

	localparam int CW = (LENGTH_BITS + 1 > CFG_DATA_BITS) ? LENGTH_BITS + 1 : CFG_DATA_BITS;
	localparam logic [CW-1:0] LIMIT = CW'(1) << LENGTH_BITS;
	localparam logic [LENGTH_BITS-1:0] CAP_RST = (MAX_AGENT_RST > (1 << LENGTH_BITS)) ?
		LENGTH_BITS'((1 << LENGTH_BITS) - 1) : LENGTH_BITS'(MAX_AGENT_RST - 1);

	logic [CW-1:0]          value_w;
	logic [LENGTH_BITS-1:0] cap_d;

	assign cfg.ready = 1'b1;
	assign value_w   = CW'(cfg.data);

	// limit of zero acts as one; above 2^LENGTH_BITS it saturates
	always_comb begin
		priority if (value_w == '0)
			cap_d = '0;
		else if (value_w > LIMIT)
			cap_d = LENGTH_BITS'(LIMIT - CW'(1));
		else
			cap_d = LENGTH_BITS'(value_w - CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_PAYLOAD_RST;
			cap_q     <= CAP_RST;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == CFG_MIN_PAYLOAD_LEN)
				min_len_q <= cfg.data[MIN_LEN_BITS-1:0];
			if (cfg.index == CFG_MAX_AGENT_LEN)
				cap_q <= cap_d;
		end
	end

endmodule

// ===== rtl/uae_parser.sv =====
// Per-packet parse state and the one-byte next-state and verdict logic.
module uae_parser import uae_pkg::*; #(
	parameter int POSITION_BITS = 16,
	parameter int LENGTH_BITS   = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               data_byte,
	input  logic                     last_byte,
	input  logic [MIN_LEN_BITS-1:0]  min_len,
	input  logic [LENGTH_BITS-1:0]   cap,
	output status_t                  status,
	output logic [POSITION_BITS-1:0] agent_start,
	output logic [LENGTH_BITS-1:0]   agent_length
);

	localparam int W  = (POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS;
	localparam int MW = (POSITION_BITS > MIN_LEN_BITS) ? POSITION_BITS : MIN_LEN_BITS;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	phase_t                   phase_q, phase_n;
	logic [3:0]               prog_q, prog_n;
	logic [POSITION_BITS-1:0] bpos_q, bpos_n;
	logic                     cr_q;
	logic [POSITION_BITS-1:0] fstart_q, fstart_n;
	logic [LENGTH_BITS-1:0]   flen_q, flen_n;
	logic                     nona_q, nona_n;
	status_t                  fail_q, fail_n;

	logic                     crlf;
	logic [3:0]               http_adv;
	logic [3:0]               ua_adv;
	logic [W-1:0]             pos_w, fs_w, cap_w, len_w, diff_w;

	assign crlf   = cr_q && (data_byte == CH_LF);
	assign bpos_n = (bpos_q != POS_MAX) ? bpos_q + POSITION_BITS'(1) : bpos_q;

	assign http_adv = (data_byte == http_char(prog_q[1:0])) ? prog_q + 4'd1 :
		(data_byte == http_char(2'd0)) ? 4'd1 : 4'd0;
	assign ua_adv = (data_byte == ua_char(prog_q)) ? prog_q + 4'd1 :
		(data_byte == ua_char(4'd0)) ? 4'd1 : 4'd0;

	assign pos_w  = W'(bpos_q);
	assign fs_w   = W'(fstart_q);
	assign cap_w  = W'(cap);
	assign diff_w = pos_w - fs_w;
	assign len_w  = (bpos_q > fstart_q) ? diff_w - W'(1) : '0;

	always_comb begin
		phase_n  = phase_q;
		prog_n   = prog_q;
		fstart_n = fstart_q;
		flen_n   = flen_q;
		nona_n   = nona_q;
		fail_n   = fail_q;
		unique case (phase_q)
			PH_METHOD: begin
				priority if (prog_q == M_IDLE && data_byte == "G")
					prog_n = M_G;
				else if (prog_q == M_IDLE && data_byte == "P")
					prog_n = M_P;
				else if (prog_q == M_G && data_byte == "E")
					prog_n = M_GE;
				else if (prog_q == M_P && data_byte == "O")
					prog_n = M_PO;
				else if (prog_q == M_PO && data_byte == "S")
					prog_n = M_POS;
				else if ((prog_q == M_GE || prog_q == M_POS) && data_byte == "T") begin
					prog_n  = M_IDLE;
					phase_n = PH_FIRST;
				end else begin
					fail_n  = ST_METHOD;
					phase_n = PH_FAILED;
				end
			end
			PH_FIRST: begin
				priority if (crlf) begin
					if (prog_q == HTTP_LEN) begin
						phase_n  = PH_HEADERS;
						prog_n   = '0;
						fstart_n = bpos_n;
					end else begin
						fail_n  = ST_NO_HTTP;
						phase_n = PH_FAILED;
					end
				end else if (prog_q < HTTP_LEN)
					prog_n = http_adv;
				else
					prog_n = prog_q;
			end
			PH_HEADERS: begin
				if (crlf) begin
					prog_n   = '0;
					fstart_n = bpos_n;
				end else if (ua_adv == UA_LEN) begin
					prog_n   = '0;
					phase_n  = PH_AGENT;
					fstart_n = bpos_n;
				end else
					prog_n = ua_adv;
			end
			PH_AGENT: begin
				if (crlf) begin
					flen_n  = (len_w > cap_w) ? cap : LENGTH_BITS'(len_w);
					phase_n = PH_DONE;
				end else if (bpos_q >= fstart_q && diff_w < cap_w && data_byte[7])
					nona_n = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		priority if (MW'(bpos_n) < MW'(min_len))
			status = ST_SHORT;
		else if (fail_n != ST_OK)
			status = fail_n;
		else if (phase_n == PH_METHOD)
			status = ST_METHOD;
		else if (phase_n == PH_FIRST)
			status = ST_NO_LINE_END;
		else if (phase_n == PH_HEADERS)
			status = (bpos_n == fstart_n) ? ST_NO_AGENT : ST_UNTERM;
		else if (phase_n == PH_AGENT)
			status = ST_UNTERM;
		else
			status = nona_n ? ST_NON_ASCII : ST_OK;
		agent_start  = (status == ST_OK) ? fstart_n : '0;
		agent_length = (status == ST_OK) ? flen_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_METHOD;
			prog_q   <= '0;
			bpos_q   <= '0;
			cr_q     <= 1'b0;
			fstart_q <= '0;
			flen_q   <= '0;
			nona_q   <= 1'b0;
			fail_q   <= ST_OK;
		end else if (step) begin
			if (last_byte) begin
				phase_q  <= PH_METHOD;
				prog_q   <= '0;
				bpos_q   <= '0;
				cr_q     <= 1'b0;
				fstart_q <= '0;
				flen_q   <= '0;
				nona_q   <= 1'b0;
				fail_q   <= ST_OK;
			end else begin
				phase_q  <= phase_n;
				prog_q   <= prog_n;
				bpos_q   <= bpos_n;
				cr_q     <= (data_byte == CH_CR);
				fstart_q <= fstart_n;
				flen_q   <= flen_n;
				nona_q   <= nona_n;
				fail_q   <= fail_n;
			end
		end
	end

endmodule

// ===== rtl/http_user_agent_extractor_top.sv =====
// HTTP User-Agent extractor: takes one TCP payload byte per cycle and gives one verdict per
// packet on its last byte (status, value offset, capped value length). Each byte passes
// through an input register and the combinational parse logic; the last byte's verdict is
// then loaded into a verdict register as that byte leaves the input register. Bytes keep
// flowing while a verdict waits; only a second last byte stalls until the pending verdict
// is taken. Register writes are taken at any time but belong between packets.
module http_user_agent_extractor_top import uae_pkg::*; #(
	parameter int POSITION_BITS = 16,
	parameter int LENGTH_BITS   = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	uae_cfg_if.sink        cfg,
	uae_pkt_if.sink        pkt,
	uae_verdict_if.source  verdict
);

	logic [MIN_LEN_BITS-1:0]  min_len_q;
	logic [LENGTH_BITS-1:0]   cap_q;

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     last_s1;
	logic                     go_s1;
	logic                     load_out;

	status_t                  status_d;
	logic [POSITION_BITS-1:0] start_d;
	logic [LENGTH_BITS-1:0]   length_d;

	logic                     out_valid_q;
	status_t                  status_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [LENGTH_BITS-1:0]   length_q;

	uae_cfg_regs #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.min_len_q(min_len_q),
		.cap_q    (cap_q)
	);

	// non-last bytes never produce a verdict and always advance
	assign go_s1     = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign load_out  = go_s1 && last_s1;
	assign pkt.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pkt.ready)
			valid_s1 <= pkt.valid;
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			byte_s1 <= pkt.data_byte;
			last_s1 <= pkt.last_byte;
		end
	end

	uae_parser #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (go_s1),
		.data_byte   (byte_s1),
		.last_byte   (last_s1),
		.min_len     (min_len_q),
		.cap         (cap_q),
		.status      (status_d),
		.agent_start (start_d),
		.agent_length(length_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (verdict.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status_d;
			start_q  <= start_d;
			length_q <= length_d;
		end
	end

	assign verdict.valid        = out_valid_q;
	assign verdict.status       = status_q;
	assign verdict.agent_start  = start_q;
	assign verdict.agent_length = length_q;

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pkt.ready |-> valid_s1 && last_s1 && out_valid_q && !verdict.ready)
		else $error("input stalled without a pending verdict");

	a_last_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> verdict.valid)
		else $error("last byte did not produce a verdict");

	a_reject_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.status != ST_OK |->
		verdict.agent_start == '0 && verdict.agent_length == '0)
		else $error("rejected packet carries agent fields");

	a_length_capped: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.valid && verdict.status == ST_OK |-> verdict.agent_length <= cap_q)
		else $error("agent length above cap");

endmodule

// ===== tb/tb_http_user_agent_extractor_top.sv =====
// Self-checking testbench for the HTTP User-Agent extractor: directed and random requests.
module tb_http_user_agent_extractor_top;
	import uae_pkg::*;

	localparam int POS_BITS        = 16;
	localparam int LEN_BITS        = 12;
	localparam int SETTLE_CYCLES   = 4;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 2'd3;

	localparam bit [95:0] HTTP_TEXT = "HTTP";
	localparam bit [95:0] AGENT_KEY = "User-Agent: ";

	typedef bit [7:0] octet_t;

	typedef struct packed {
		status_t             status;
		logic [POS_BITS-1:0] start;
		logic [LEN_BITS-1:0] length;
	} verdict_t;

	logic clk;
	logic arst_n;

	uae_cfg_if                                                 cfg_ch();
	uae_pkt_if                                                 pkt_ch();
	uae_verdict_if #(.POSITION_BITS(POS_BITS), .LENGTH_BITS(LEN_BITS)) verdict_ch();

	http_user_agent_extractor_top #(
		.POSITION_BITS(POS_BITS),
		.LENGTH_BITS  (LEN_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pkt    (pkt_ch),
		.verdict(verdict_ch)
	);

	// register shadow and parser state
	bit [7:0]            min_len_reg;
	bit [12:0]           agent_limit_reg;
	bit [POS_BITS-1:0]   byte_cnt;
	phase_t              ph;
	bit [3:0]            match_cnt;
	bit                  cr_seen;
	int unsigned         field_start;
	int unsigned         value_len;
	bit                  high_seen;
	status_t             fail_code;

	verdict_t verdicts_due[$];
	octet_t   pkt_bytes[$];

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_stall_left = 0;
	int rx_hold_left = 0;
	int err_cnt = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned agent_cap();
		int unsigned lim;
		lim = 32'(agent_limit_reg);
		if (lim < 1)
			lim = 1;
		if (lim > (1 << LEN_BITS))
			lim = 1 << LEN_BITS;
		return lim - 1;
	endfunction

	// pattern whose first letter occurs nowhere else in it
	function automatic bit [3:0] next_match(input bit [95:0] pat, input bit [3:0] plen,
			input bit [3:0] k, input octet_t b);
		int idx;
		idx = 8 * (int'(plen) - 1 - int'(k));
		if (b == pat[idx +: 8])
			return k + 4'd1;
		return (b == pat[8 * (int'(plen) - 1) +: 8]) ? 4'd1 : 4'd0;
	endfunction

	task automatic clear_packet_state();
		byte_cnt    = '0;
		ph          = PH_METHOD;
		match_cnt   = '0;
		cr_seen     = 1'b0;
		field_start = 0;
		value_len   = 0;
		high_seen   = 1'b0;
		fail_code   = ST_OK;
	endtask

	task automatic parse_payload_byte(input octet_t b, input bit last);
		int unsigned here, len, cap;
		bit crlf;
		status_t st;
		verdict_t v;
		here = 32'(byte_cnt);
		if (byte_cnt != '1)
			byte_cnt++;
		crlf = cr_seen && b == CH_LF;
		cr_seen = (b == CH_CR);
		cap = agent_cap();
		case (ph)
			PH_METHOD: begin
				if (match_cnt == M_IDLE && b == "G") match_cnt = M_G;
				else if (match_cnt == M_IDLE && b == "P") match_cnt = M_P;
				else if (match_cnt == M_G && b == "E") match_cnt = M_GE;
				else if (match_cnt == M_P && b == "O") match_cnt = M_PO;
				else if (match_cnt == M_PO && b == "S") match_cnt = M_POS;
				else if ((match_cnt == M_GE || match_cnt == M_POS) && b == "T") begin
					match_cnt = M_IDLE;
					ph = PH_FIRST;
				end else begin
					fail_code = ST_METHOD;
					ph = PH_FAILED;
				end
			end
			PH_FIRST: begin
				if (crlf) begin
					if (match_cnt == HTTP_LEN) begin
						ph = PH_HEADERS;
						match_cnt = 4'd0;
						field_start = 32'(byte_cnt);
					end else begin
						fail_code = ST_NO_HTTP;
						ph = PH_FAILED;
					end
				end else if (match_cnt < HTTP_LEN) begin
					match_cnt = next_match(HTTP_TEXT, HTTP_LEN, match_cnt, b);
				end
			end
			PH_HEADERS: begin
				if (crlf) begin
					match_cnt = 4'd0;
					field_start = 32'(byte_cnt);
				end else begin
					match_cnt = next_match(AGENT_KEY, UA_LEN, match_cnt, b);
					if (match_cnt == UA_LEN) begin
						match_cnt = 4'd0;
						ph = PH_AGENT;
						field_start = 32'(byte_cnt);
					end
				end
			end
			PH_AGENT: begin
				if (crlf) begin
					len = (here >= field_start + 1) ? here - 1 - field_start : 0;
					value_len = (len > cap) ? cap : len;
					ph = PH_DONE;
				end else if (here >= field_start && here - field_start < cap && b > 8'd127) begin
					high_seen = 1'b1;
				end
			end
			default: ;
		endcase
		if (last) begin
			if (byte_cnt < POS_BITS'(min_len_reg)) st = ST_SHORT;
			else if (fail_code != ST_OK) st = fail_code;
			else if (ph == PH_METHOD) st = ST_METHOD;
			else if (ph == PH_FIRST) st = ST_NO_LINE_END;
			else if (ph == PH_HEADERS)
				st = (32'(byte_cnt) == field_start) ? ST_NO_AGENT : ST_UNTERM;
			else if (ph == PH_AGENT) st = ST_UNTERM;
			else st = high_seen ? ST_NON_ASCII : ST_OK;
			v.status = st;
			v.start  = (st == ST_OK) ? field_start[POS_BITS-1:0] : '0;
			v.length = (st == ST_OK) ? value_len[LEN_BITS-1:0] : '0;
			verdicts_due.push_back(v);
			clear_packet_state();
		end
	endtask

	task automatic push_byte(input octet_t b, input bit last);
		int gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pkt_ch.valid     <= 1'b1;
		pkt_ch.data_byte <= b;
		pkt_ch.last_byte <= last;
		do @(posedge clk); while (pkt_ch.ready !== 1'b1);
		parse_payload_byte(b, last);
		@(negedge clk);
	endtask

	task automatic send_packet();
		int n;
		n = pkt_bytes.size();
		for (int i = 0; i < n; i++)
			push_byte(pkt_bytes[i], i == n - 1);
		pkt_bytes.delete();
	endtask

	task automatic add_byte(input octet_t b);
		pkt_bytes.push_back(b);
	endtask

	// newline expands to CRLF, tab stands for a lone CR
	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			if (s[i] == "\n") begin
				add_byte(CH_CR);
				add_byte(CH_LF);
			end else if (s[i] == "\t") begin
				add_byte(CH_CR);
			end else begin
				add_byte(s[i]);
			end
		end
	endtask

	task automatic add_random_text(input int n);
		repeat (n) add_byte(octet_t'($urandom_range(32, 126)));
	endtask

	task automatic add_agent_value(input int len, input int hi_at);
		for (int i = 0; i < len; i++)
			add_byte(octet_t'(i == hi_at ? $urandom_range(128, 255) : $urandom_range(32, 126)));
	endtask

	task automatic send_text(input string s);
		pkt_bytes.delete();
		add_text(s);
		send_packet();
	endtask

	task automatic drain();
		pkt_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == CFG_MIN_PAYLOAD_LEN)
			min_len_reg = val[7:0];
		else if (idx == CFG_MAX_AGENT_LEN)
			agent_limit_reg = val;
		@(negedge clk);
	endtask

	task automatic configure(input int min_val, input int max_val);
		drain();
		write_reg(CFG_MIN_PAYLOAD_LEN, CFG_DATA_BITS'(min_val));
		write_reg(CFG_MAX_AGENT_LEN, CFG_DATA_BITS'(max_val));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic build_request();
		int kind, cut, vlen, hi_at;
		kind = $urandom_range(0, 11);
		pkt_bytes.delete();
		if (kind == 0) begin
			repeat ($urandom_range(1, 24)) add_byte(octet_t'($urandom_range(0, 255)));
			return;
		end
		if (kind == 1) begin
			case ($urandom_range(0, 4))
				0: add_text("GE");
				1: add_text("POT");
				2: add_text("PUT");
				3: add_text("GXT");
				default: add_text("HEAD");
			endcase
		end else if ($urandom_range(0, 1)) begin
			add_text("GET");
		end else begin
			add_text("POST");
		end
		add_text(" /");
		add_random_text($urandom_range(0, 5));
		add_text(" ");
		if (kind == 2) begin
			add_text("HTXP/1.1");
		end else begin
			if ($urandom_range(0, 3) == 0)
				add_text("HT");
			add_text("HTTP/1.1");
		end
		if (kind == 3) begin
			add_random_text($urandom_range(0, 3));
			return;
		end
		add_text("\n");
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(0, 4) == 0)
				add_text("User-Agen");
			add_random_text($urandom_range(1, 5));
			add_text(": ");
			add_random_text($urandom_range(0, 8));
			if ($urandom_range(0, 5) == 0)
				add_text("\tx");
			add_text("\n");
		end
		if (kind == 4) begin
			if ($urandom_range(0, 1))
				add_random_text($urandom_range(1, 6));
			return;
		end
		if ($urandom_range(0, 5) == 0)
			add_text("UUser-Agent");
		add_text("User-Agent: ");
		vlen = $urandom_range(0, 14);
		hi_at = (kind == 5 && vlen > 0) ? $urandom_range(0, vlen - 1) : -1;
		add_agent_value(vlen, hi_at);
		if ($urandom_range(0, 7) == 0)
			add_text("\t;");
		if (kind == 6)
			return;
		add_text("\n");
		if ($urandom_range(0, 1)) begin
			add_text("Accept: ");
			add_random_text($urandom_range(0, 6));
			add_text("\n");
		end
		add_text("\n");
		if (kind == 7) begin
			cut = $urandom_range(1, pkt_bytes.size());
			while (pkt_bytes.size() > cut)
				void'(pkt_bytes.pop_back());
		end
	endtask

	task automatic test_reset_defaults();
		send_text("GET /index.html HTTP/1.1\nHost: a\nUser-Agent: Mozilla/5.0\n\n");
		send_text("POST /x HTTP/1.0\nUser-Agent: curl\n\n");
		send_text("GET / HTTP/1.1\n");
		send_text("GET /\n");
	endtask

	task automatic test_methods();
		configure(0, 256);
		send_text("G");
		send_text("POS");
		send_text("PUT / HTTP/1.1\n\n");
		send_text("GEX / HTTP/1.1\n\n");
		send_text("HEAD / HTTP/1.1\n\n");
	endtask

	task automatic test_line_rules();
		send_text("GET / HTXP/1.1\nUser-Agent: a\n\n");
		send_text("POST /a HTTP/1.1");
		send_text("GET / HTTP/1.1\nHost: x");
		send_text("GET / HTTP/1.1\nHost: x\n");
		send_text("GET / HTTP/1.1\nUser-Agent: abc");
		send_text("GET /\tx HHTTP/1.1\nUUser-Agent: a\tb\n\n");
		send_text("POST / HTTP/1.1\nUser-Agent: \n\n");
	endtask

	task automatic test_agent_limits();
		configure(0, 0);
		pkt_bytes.delete();
		add_text("GET / HTTP\nUser-Agent: ");
		add_agent_value(3, 0);
		add_text("\n\n");
		send_packet();
		configure(0, 2);
		add_text("GET / HTTP\nUser-Agent: ");
		add_agent_value(3, 1);
		add_text("\n\n");
		send_packet();
		add_text("GET / HTTP\nUser-Agent: ");
		add_agent_value(3, 0);
		add_text("\n\n");
		send_packet();
		configure(0, 8191);
		tx_idle = 1'b0;
		add_text("GET / HTTP\nUser-Agent: ");
		add_agent_value(20, 19);
		add_text("\n\n");
		send_packet();
		configure(0, 4096);
		add_text("POST / HTTP\nUser-Agent: ");
		add_agent_value(20, -1);
		add_text("\n\n");
		send_packet();
		tx_idle = 1'b1;
		configure(255, 256);
		send_text("GET / HTTP/1.1\nUser-Agent: short one\n\n");
		drain();
		write_reg(CFG_SPARE_LO, CFG_DATA_BITS'($urandom_range(0, 8191)));
		write_reg(CFG_SPARE_HI, CFG_DATA_BITS'($urandom_range(0, 8191)));
		cfg_ch.valid <= 1'b0;
		send_text("GET / HTTP/1.1\nUser-Agent: still short\n\n");
		// upper data bits beyond the register width are dropped
		configure(13'h1F00, 256);
		send_text("G");
	endtask

	task automatic test_backpressure();
		configure(0, 256);
		@(posedge clk);
		rx_hold_left = HOLD_OFF_CYCLES;
		@(negedge clk);
		repeat (24) begin
			if ($urandom_range(0, 1))
				add_text("G");
			else
				repeat ($urandom_range(1, 3)) add_byte(octet_t'($urandom_range(0, 255)));
			send_packet();
		end
	endtask

	task automatic test_random_traffic();
		int phase_bytes;
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: configure(16, 256);
				1: configure($urandom_range(0, 40), $urandom_range(2, 20));
				2: configure(0, 4096);
				3: configure($urandom_range(0, 60), $urandom_range(2, 20));
				default: configure($urandom_range(0, 255), $urandom_range(0, 8191));
			endcase
			tx_idle = (p != 2) && (p != 4);
			rx_idle = (p != 2) && (p != 3);
			phase_bytes = 0;
			while (phase_bytes < 30) begin
				build_request();
				phase_bytes += pkt_bytes.size();
				send_packet();
			end
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			verdict_ch.ready <= 1'b0;
			rx_hold_left--;
		end else if (rx_stall_left > 0) begin
			verdict_ch.ready <= 1'b0;
			rx_stall_left--;
		end else begin
			verdict_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_verdicts
		verdict_t want;
		if (arst_n === 1'b1 && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
			rx_stall_left = rx_idle ? $urandom_range(0, 7) : 0;
			if (verdicts_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected verdict: status %0d start %0d length %0d",
						verdict_ch.status, verdict_ch.agent_start, verdict_ch.agent_length);
			end else begin
				want = verdicts_due.pop_front();
				if (verdict_ch.status !== want.status || verdict_ch.agent_start !== want.start ||
						verdict_ch.agent_length !== want.length) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("verdict mismatch: expected status %0d start %0d length %0d, %s %0d %s %0d %s %0d",
							want.status, want.start, want.length, "got status",
							verdict_ch.status, "start", verdict_ch.agent_start, "length",
							verdict_ch.agent_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pkt_ch.valid === 1'b1 && pkt_ch.ready === 1'b1) ||
				(verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		pkt_ch.valid      = 1'b0;
		pkt_ch.data_byte  = '0;
		pkt_ch.last_byte  = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = '0;
		cfg_ch.data       = '0;
		verdict_ch.ready  = 1'b0;
		min_len_reg       = MIN_PAYLOAD_RST;
		agent_limit_reg   = 13'(MAX_AGENT_RST);
		clear_packet_state();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_methods();
		test_line_rules();
		test_agent_limits();
		test_backpressure();
		test_random_traffic();
		drain();
		if (err_cnt == 0 && verdicts_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
